[src/bitmap_page_allocator_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap page allocator
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of clk_i, quiet while rst_ni is low.
`define BPA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bpa assertion failed");
// Checked on every rising edge of clk_i, also during reset.
`define BPA_ASSERT_NR(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("bpa assertion failed");
`else
`define BPA_ASSERT(name, prop)
`define BPA_ASSERT_NR(name, prop)
`endif
`endif

[src/bpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared types, codes and fixed widths of the page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int COUNT_W    = 11;
  localparam int ADDR_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int BASE_W     = 20;
  localparam int POOL_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int WORD_W     = 32;
  localparam int WORD_SHIFT = 5;

  localparam logic [BASE_W-1:0] BASE_RESET = 20'd256;
  localparam logic [POOL_W-1:0] POOL_RESET = 11'd1024;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_NOSPACE = 2'd1,
    STATUS_IGNORED = 2'd2,
    STATUS_RANGE   = 2'd3
  } status_e;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE_PAGE = 2'd0,
    CFG_POOL_PAGES     = 2'd1
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE_IDX,
    ST_FREE_CHK,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic               action;
    logic [COUNT_W-1:0] page_count;
    logic [ADDR_W-1:0]  page_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   page_address_out;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic                  found;
    logic [WORD_SHIFT-1:0] pos;
  } scan_res_t;

endpackage

[src/bitmap_page_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator core
// First-fit contiguous page allocator over a used-page bitmap held in RAM.
// ----------------------------------------------------------------------------
// Requests enter on the in channel (in_valid_i, in_stall_o, in_i) and each
// one produces exactly one response on the out channel (out_valid_o,
// out_stall_i, out_o). An allocate request scans the bitmap from page 0 one
// 32-page word per cycle, up to the last word covering the pool. A run that
// is found goes through a read of its first word, a read-modify-write of
// each bitmap word it touches and the response state. A failed allocation
// answers once the last word of the pool is scanned; a free checks the
// pool base, then the pool end, before it marks; an ignored request (zero
// count, null free address) goes straight to the response state.
// The block holds in_stall_o high while it works on a request, so it takes
// one request at a time; the throughput is set by the bitmap RAM, with one
// read and one write port, and the word scanner that walks it.
// After reset every page is free: the block first sweeps the bitmap RAM to
// zero, one word per cycle, and stalls the in channel until the sweep ends.
// The cfg channel is always ready; the user must write the pool registers
// only while no request is in flight, which the block itself does not enforce.
// A finished response sits in the output register; a new request is taken
// while it waits, and a second response waits inside the block until the
// receiver lowers out_stall_i.
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_core_macros.svh"

module bitmap_page_allocator_core
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES  = 1024,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  req_t                  in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rsp_t                  out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Bitmap geometry. Page indices keep at least enough bits to split into a
  // word number and a bit position. PAGE_BYTES must be a power of two.
  localparam int WORDS      = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int WADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PCLOG      = $clog2(MAX_PAGES + 1);
  localparam int PIDX_W     = (PCLOG > WORD_SHIFT + 1) ? PCLOG : WORD_SHIFT + 1;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  // Control state.
  state_e               state_q, state_d;
  logic [WADDR_W-1:0]   scan_word_q, scan_word_d;
  logic                 out_valid_q, out_valid_d;
  logic [BASE_W-1:0]    base_q;
  logic [POOL_W-1:0]    pool_pages_q;

  // Request and working registers.
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [PIDX_W-1:0]    run_q, run_d;
  logic [PIDX_W-1:0]    lo_q, lo_d;
  logic [PIDX_W-1:0]    hi_q, hi_d;
  logic [WADDR_W-1:0]   mark_word_q, mark_word_d;
  logic                 mark_val_q, mark_val_d;
  logic [ADDR_W-1:0]    idx_q, idx_d;
  logic [ADDR_W-1:0]    res_addr_q, res_addr_d;
  status_e              res_status_q, res_status_d;
  rsp_t                 out_q, out_d;

  // Bitmap RAM port.
  logic                 mem_we;
  logic [WADDR_W-1:0]   mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;
  logic [WADDR_W-1:0]   mem_raddr;
  logic [WORD_W-1:0]    mem_rdata;

  // Derived values.
  logic [PIDX_W-1:0]    npages;
  logic [WADDR_W-1:0]   last_word;
  logic [ADDR_W-1:0]    word_base;
  logic [ADDR_W-1:0]    rem_pages;
  logic [WORD_SHIFT:0]  lim;
  logic [WORD_W-1:0]    oob_mask;
  logic [WORD_W-1:0]    scan_used;
  scan_res_t            scan_res;
  logic [PIDX_W-1:0]    scan_run;
  logic [WADDR_W-1:0]   lo_word;
  logic [WADDR_W-1:0]   hi_word;
  logic [WORD_SHIFT-1:0] mark_lb;
  logic [WORD_SHIFT-1:0] mark_ub;
  logic [WORD_W-1:0]    mark_mask;
  logic [ADDR_W-1:0]    free_pg;
  logic [ADDR_W-1:0]    alloc_end;
  logic                 in_accept;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Pool size, saturated to the bitmap size.
  always_comb begin
    if (32'(pool_pages_q) > 32'(MAX_PAGES)) begin
      npages = PIDX_W'(MAX_PAGES);
    end else begin
      npages = PIDX_W'(pool_pages_q);
    end
    if (npages == '0) begin
      last_word = '0;
    end else begin
      last_word = WADDR_W'((npages - PIDX_W'(1)) >> WORD_SHIFT);
    end
  end

  // Pages at or beyond the pool end read as used while scanning.
  always_comb begin
    word_base = 32'(scan_word_q) << WORD_SHIFT;
    if (32'(npages) > word_base) begin
      rem_pages = 32'(npages) - word_base;
    end else begin
      rem_pages = '0;
    end
    if (rem_pages >= 32'(WORD_W)) begin
      lim = (WORD_SHIFT + 1)'(WORD_W);
    end else begin
      lim = rem_pages[WORD_SHIFT:0];
    end
    for (int j = 0; j < WORD_W; j++) begin
      oob_mask[j] = ((WORD_SHIFT + 1)'(j) >= lim);
    end
    scan_used = mem_rdata | oob_mask;
  end

  bpa_word_scan #(
    .RUN_W (PIDX_W)
  ) u_scan (
    .used_i  (scan_used),
    .run_i   (run_q),
    .count_i (count_q),
    .res_o   (scan_res),
    .run_o   (scan_run)
  );

  // Bit range of the current word that lies inside the run being marked.
  always_comb begin
    lo_word = WADDR_W'(lo_q >> WORD_SHIFT);
    hi_word = WADDR_W'(hi_q >> WORD_SHIFT);
    mark_lb = (mark_word_q == lo_word) ? lo_q[WORD_SHIFT-1:0] : '0;
    mark_ub = (mark_word_q == hi_word) ? hi_q[WORD_SHIFT-1:0] : '1;
    for (int j = 0; j < WORD_W; j++) begin
      mark_mask[j] = (WORD_SHIFT'(j) >= mark_lb) && (WORD_SHIFT'(j) <= mark_ub);
    end
  end

  assign free_pg   = addr_q >> PAGE_SHIFT;
  assign alloc_end = word_base | 32'(scan_res.pos);

  bpa_bitmap_ram #(
    .DEPTH (WORDS),
    .AW    (WADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer: next state, RAM control and working register updates.
  always_comb begin
    state_d      = state_q;
    scan_word_d  = scan_word_q;
    count_d      = count_q;
    addr_d       = addr_q;
    run_d        = run_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mark_word_d  = mark_word_q;
    mark_val_d   = mark_val_q;
    idx_d        = idx_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mem_we       = 1'b0;
    mem_waddr    = scan_word_q;
    mem_wdata    = '0;
    mem_raddr    = '0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = scan_word_q;
        if (scan_word_q == WADDR_W'(WORDS - 1)) begin
          scan_word_d = '0;
          state_d     = ST_IDLE;
        end else begin
          scan_word_d = scan_word_q + WADDR_W'(1);
        end
      end

      ST_IDLE: begin
        // Word 0 is read here so that it is ready on the first scan cycle.
        mem_raddr = '0;
        if (in_accept) begin
          count_d    = in_i.page_count;
          addr_d     = in_i.page_address;
          res_addr_d = '0;
          if (in_i.page_count == '0) begin
            res_status_d = STATUS_IGNORED;
            state_d      = ST_RESP;
          end else if (in_i.action == ACT_ALLOC) begin
            scan_word_d = '0;
            run_d       = '0;
            state_d     = ST_SCAN;
          end else if (in_i.page_address == '0) begin
            res_status_d = STATUS_IGNORED;
            state_d      = ST_RESP;
          end else begin
            state_d = ST_FREE_IDX;
          end
        end
      end

      ST_SCAN: begin
        mem_raddr = scan_word_q + WADDR_W'(1);
        if (scan_res.found) begin
          hi_d         = PIDX_W'(alloc_end);
          lo_d         = PIDX_W'(alloc_end + 32'd1 - 32'(count_q));
          mark_val_d   = 1'b1;
          res_status_d = STATUS_DONE;
          state_d      = ST_MARK_RD;
        end else if (scan_word_q == last_word) begin
          res_addr_d   = '0;
          res_status_d = STATUS_NOSPACE;
          state_d      = ST_RESP;
        end else begin
          scan_word_d = scan_word_q + WADDR_W'(1);
          run_d       = scan_run;
        end
      end

      ST_FREE_IDX: begin
        if (free_pg < 32'(base_q)) begin
          res_status_d = STATUS_RANGE;
          state_d      = ST_RESP;
        end else begin
          idx_d   = free_pg - 32'(base_q);
          state_d = ST_FREE_CHK;
        end
      end

      ST_FREE_CHK: begin
        if ((idx_q > 32'(npages)) ||
            ((33'(idx_q) + 33'(count_q)) > 33'(npages))) begin
          res_status_d = STATUS_RANGE;
          state_d      = ST_RESP;
        end else begin
          lo_d         = PIDX_W'(idx_q);
          hi_d         = PIDX_W'(idx_q + 32'(count_q) - 32'd1);
          mark_val_d   = 1'b0;
          res_status_d = STATUS_DONE;
          state_d      = ST_MARK_RD;
        end
      end

      ST_MARK_RD: begin
        mem_raddr   = lo_word;
        mark_word_d = lo_word;
        if (mark_val_q) begin
          res_addr_d = (32'(base_q) + 32'(lo_q)) << PAGE_SHIFT;
        end
        state_d = ST_MARK_WR;
      end

      ST_MARK_WR: begin
        // Write back the current word while the next one is being read.
        mem_we    = 1'b1;
        mem_waddr = mark_word_q;
        mem_wdata = mark_val_q ? (mem_rdata | mark_mask) : (mem_rdata & ~mark_mask);
        mem_raddr = mark_word_q + WADDR_W'(1);
        if (mark_word_q == hi_word) begin
          state_d = ST_RESP;
        end else begin
          mark_word_d = mark_word_q + WADDR_W'(1);
        end
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.page_address_out = res_addr_q;
          out_d.status           = res_status_q;
          out_valid_d            = 1'b1;
          state_d                = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      scan_word_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_word_q <= scan_word_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= BASE_RESET;
      pool_pages_q <= POOL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_POOL_BASE_PAGE: base_q       <= cfg_data_i[BASE_W-1:0];
        CFG_POOL_PAGES:     pool_pages_q <= cfg_data_i[POOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    count_q      <= count_d;
    addr_q       <= addr_d;
    run_q        <= run_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mark_word_q  <= mark_word_d;
    mark_val_q   <= mark_val_d;
    idx_q        <= idx_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    out_q        <= out_d;
  end

  // The scan never walks past the last word of the pool.
  `BPA_ASSERT(a_scan_in_pool, (state_q == ST_SCAN) |-> (scan_word_q <= last_word))
  // Marking stops at the word holding the last page of the run.
  `BPA_ASSERT(a_mark_in_run, (state_q == ST_MARK_WR) |-> (mark_word_q <= hi_word))
  // A failed allocation never reports an address.
  `BPA_ASSERT(a_nospace_null, (out_valid_o && (out_o.status == STATUS_NOSPACE)) |-> (out_o.page_address_out == '0))
  // A response only appears out of the response state.
  `BPA_ASSERT_NR(a_resp_source, $rose(out_valid_q) |-> ($past(state_q) == ST_RESP))

endmodule

[src/bpa_bitmap_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap word memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpa_bitmap_ram
  import bpa_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/bpa_word_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap word scanner
// Finds the first page in one word where a free run reaches the request count.
// ----------------------------------------------------------------------------
module bpa_word_scan
  import bpa_pkg::*;
#(
  parameter int RUN_W = 11
) (
  input  logic [WORD_W-1:0]  used_i,
  input  logic [RUN_W-1:0]   run_i,
  input  logic [COUNT_W-1:0] count_i,
  output scan_res_t          res_o,
  output logic [RUN_W-1:0]   run_o
);

  localparam int VAL_W = ((RUN_W > WORD_SHIFT + 1) ? RUN_W : WORD_SHIFT + 1) + 1;
  localparam int CMP_W = (VAL_W > COUNT_W) ? VAL_W : COUNT_W;

  logic [WORD_SHIFT:0] zrun [WORD_W];
  logic [VAL_W-1:0]    run_at [WORD_W];
  logic [WORD_W-1:0]   hit;

  // Zero run ending at each bit: distance to the nearest used bit below it.
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      zrun[j] = (WORD_SHIFT + 1)'(j + 1);
      for (int k = 0; k <= j; k++) begin
        if (used_i[k]) begin
          zrun[j] = (WORD_SHIFT + 1)'(j - k);
        end
      end
      if (zrun[j] == (WORD_SHIFT + 1)'(j + 1)) begin
        run_at[j] = VAL_W'(run_i) + VAL_W'(j + 1);
      end else begin
        run_at[j] = VAL_W'(zrun[j]);
      end
      hit[j] = !used_i[j] && (CMP_W'(run_at[j]) >= CMP_W'(count_i));
    end
  end

  always_comb begin
    res_o.found = |hit;
    res_o.pos   = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit[j]) begin
        res_o.pos = WORD_SHIFT'(j);
      end
    end
  end

  assign run_o = RUN_W'(run_at[WORD_W-1]);

endmodule

[tb/sv/bitmap_page_allocator_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator core testbench
// Sends allocate and free requests through the stall handshake and checks
// each response against a first-fit model of the used-page bitmap kept here.
// A directed part covers ignored, out-of-range, unaligned, oversized,
// wrapping and pool-resize requests. Random traffic then runs under three
// pool settings and three sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_core_tb;
  import bpa_pkg::*;

  localparam int MAX_PAGES     = 1024;
  localparam int PAGE_BYTES    = 4096;
  localparam int PAGE_SHIFT    = 12;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 100;
  localparam int REPORT_MAX    = 10;
  localparam int PHASE_ITEMS   = 185;

  // The two index codes that name no register; writes to them change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // A run of pages handed out by the allocator and not yet given back.
  typedef struct {
    int unsigned first_page;
    int unsigned pages;
  } page_run_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  req_t                  in_i        = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  rsp_t                  out_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Model of the block: used-page bitmap and the two pool registers.
  bit                page_used [MAX_PAGES];
  logic [BASE_W-1:0] base_page = BASE_RESET;
  logic [POOL_W-1:0] pool_size = POOL_RESET;
  bit                last_alloc_ok;
  int unsigned       last_alloc_page;

  rsp_t      pending_rsp_q[$];
  page_run_t live_runs[$];

  int idle_pct  = 20;
  int stall_pct = 67;
  int idle_cycles;
  int mismatches, responses, requests, allocs, frees, reg_writes;
  int nospace_cnt, range_cnt, ignored_cnt;

  bitmap_page_allocator_core #(
    .MAX_PAGES (MAX_PAGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // The receiver stalls at random, one fresh decision per cycle.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Byte address of a pool page under the current base, wrapped to 32 bits.
  function automatic logic [ADDR_W-1:0] page_to_address(input longint unsigned page);
    return ADDR_W'((longint'(base_page) + page) * PAGE_BYTES);
  endfunction

  // First-fit allocation and range-checked free over the model bitmap.
  function automatic rsp_t predict_page_response(input req_t r);
    rsp_t            res;
    int unsigned     npages;
    int unsigned     run;
    int unsigned     start;
    longint unsigned pg;
    longint unsigned idx;
    bit              found;
    res.page_address_out = '0;
    res.status           = STATUS_IGNORED;
    npages        = (pool_size > MAX_PAGES) ? MAX_PAGES : pool_size;
    run           = 0;
    start         = 0;
    found         = 1'b0;
    last_alloc_ok = 1'b0;
    if (r.page_count == '0) return res;
    if (r.action == ACT_ALLOC) begin
      for (int i = 0; i < npages && !found; i++) begin
        if (page_used[i]) begin
          run = 0;
        end else begin
          run++;
          if (run == r.page_count) begin
            found = 1'b1;
            start = i + 1 - r.page_count;
          end
        end
      end
      if (found) begin
        for (int p = start; p < start + r.page_count; p++) page_used[p] = 1'b1;
        res.page_address_out = page_to_address(start);
        res.status           = STATUS_DONE;
        last_alloc_ok        = 1'b1;
        last_alloc_page      = start;
      end else begin
        res.status = STATUS_NOSPACE;
      end
    end else if (r.page_address != '0) begin
      // Low address bits are dropped, so an unaligned free hits its page.
      pg = r.page_address >> PAGE_SHIFT;
      if (pg < base_page) begin
        res.status = STATUS_RANGE;
      end else begin
        idx = pg - base_page;
        if (idx > npages || r.page_count > npages - idx) begin
          res.status = STATUS_RANGE;
        end else begin
          for (int k = 0; k < r.page_count; k++) page_used[idx + k] = 1'b0;
          res.status = STATUS_DONE;
        end
      end
    end
    return res;
  endfunction

  task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%0t: %s: expected status %0d address %h, got status %0d address %h",
               $realtime, what, want.status, want.page_address_out, got.status,
               got.page_address_out);
    end
  endtask

  // Every accepted response is matched against the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      responses++;
      if (pending_rsp_q.size() == 0) begin
        note_mismatch("response with no request waiting", '0, out_o);
      end else begin
        want = pending_rsp_q.pop_front();
        if (out_o.status !== want.status ||
            out_o.page_address_out !== want.page_address_out) begin
          note_mismatch("response mismatch", want, out_o);
        end
      end
    end
  end

  // The run ends if no handshake of any kind happens for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("bitmap_page_allocator_core_tb NOT OK");
      $finish;
    end
  end

  // Valid is left high after acceptance so back-to-back requests never drop
  // it; it is lowered only for an idle cycle or by drain_responses. Each
  // cycle before a request the sender idles with probability idle_pct.
  task automatic send_request(input action_e act, input int unsigned count,
                              input logic [ADDR_W-1:0] addr);
    req_t r;
    rsp_t want;
    r.action       = act;
    r.page_count   = COUNT_W'(count);
    r.page_address = addr;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= r;
    do @(posedge clk_i); while (in_stall_o);
    want = predict_page_response(r);
    pending_rsp_q.push_back(want);
    requests++;
    if (act == ACT_ALLOC) allocs++;
    else frees++;
    case (want.status)
      STATUS_NOSPACE: nospace_cnt++;
      STATUS_RANGE:   range_cnt++;
      STATUS_IGNORED: ignored_cnt++;
      default: ;
    endcase
  endtask

  task automatic drain_responses();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_rsp_q.size() != 0);
  endtask

  // Only called with the block idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CFG_POOL_BASE_PAGE: base_page = value[BASE_W-1:0];
      CFG_POOL_PAGES:     pool_size = value[POOL_W-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_ignored_requests();
    send_request(ACT_ALLOC, 0, 32'hFFFF_FFFF);
    send_request(ACT_FREE, 5, '0);
    send_request(ACT_FREE, 0, page_to_address(0));
  endtask

  task automatic test_allocation_extremes();
    send_request(ACT_ALLOC, 1, '0);
    // Page 0 is taken, so a full-pool request cannot fit.
    send_request(ACT_ALLOC, MAX_PAGES, '0);
    send_request(ACT_FREE, 1, page_to_address(0) | ADDR_W'(PAGE_BYTES - 1));
    send_request(ACT_ALLOC, MAX_PAGES, $urandom);
    send_request(ACT_ALLOC, 1, $urandom);
    send_request(ACT_FREE, MAX_PAGES, page_to_address(0));
  endtask

  task automatic test_free_range();
    send_request(ACT_FREE, 1, page_to_address(0) - PAGE_BYTES);
    send_request(ACT_FREE, 2, page_to_address(MAX_PAGES - 1));
    send_request(ACT_FREE, 1, page_to_address(MAX_PAGES));
    // Freeing pages that are already free leaves them free.
    send_request(ACT_FREE, 4, page_to_address(MAX_PAGES - 4));
    send_request(ACT_FREE, 1, 32'hFFFF_FFFF);
  endtask

  task automatic test_pool_resize();
    drain_responses();
    write_register(CFG_POOL_PAGES, 32'd40);
    send_request(ACT_ALLOC, 41, '0);
    send_request(ACT_ALLOC, 40, '0);
    drain_responses();
    write_register(CFG_POOL_PAGES, 32'd0);
    send_request(ACT_ALLOC, 1, '0);
    send_request(ACT_FREE, 1, page_to_address(0));
    drain_responses();
    // Writes to unused indexes must not disturb either register.
    write_register(CFG_SPARE_LO, $urandom);
    write_register(CFG_SPARE_HI, $urandom);
    // An oversized pool size saturates to the bitmap size; the 40 pages
    // taken above keep their bits across the resizes.
    write_register(CFG_POOL_PAGES, 32'hFFFF_FFFF);
    send_request(ACT_ALLOC, 1, '0);
    send_request(ACT_FREE, 41, page_to_address(0));
  endtask

  task automatic test_address_wrap();
    drain_responses();
    write_register(CFG_POOL_BASE_PAGE, 32'hFFFF_FFFF);
    send_request(ACT_ALLOC, 1, '0);
    // The second page lies past 4 GiB and wraps to address zero.
    send_request(ACT_ALLOC, 1, '0);
    send_request(ACT_FREE, 1, 32'hFFFF_F000);
    send_request(ACT_FREE, 1, '0);
    drain_responses();
    write_register(CFG_POOL_BASE_PAGE, 32'd0);
    send_request(ACT_FREE, 1, page_to_address(1));
  endtask

  // Mostly allocations and matching frees of live runs, the rest noise.
  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input logic [BASE_W-1:0] base,
                                     input logic [POOL_W-1:0] pages);
    page_run_t   blk;
    int          pick;
    int unsigned sel;
    int unsigned count;
    int unsigned size_sel;
    drain_responses();
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    write_register(CFG_POOL_BASE_PAGE, {12'($urandom), base});
    write_register(CFG_POOL_PAGES, {21'($urandom), pages});
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      sel = $urandom_range(99);
      if (sel < 40 || (sel < 80 && live_runs.size() == 0)) begin
        size_sel = $urandom_range(99);
        if (size_sel < 70) count = $urandom_range(1, 8);
        else if (size_sel < 95) count = $urandom_range(9, 64);
        else count = $urandom_range(65, MAX_PAGES);
        send_request(ACT_ALLOC, count, $urandom);
        if (last_alloc_ok) live_runs.push_back('{last_alloc_page, count});
      end else if (sel < 80) begin
        pick = $urandom_range(live_runs.size() - 1);
        blk  = live_runs[pick];
        live_runs.delete(pick);
        send_request(ACT_FREE, blk.pages,
                     page_to_address(blk.first_page) | ADDR_W'($urandom_range(PAGE_BYTES - 1)));
      end else if (sel < 88) begin
        // Frees around the top of the pool probe the range check.
        send_request(ACT_FREE, $urandom_range(0, 16),
                     page_to_address($urandom_range(pool_size + 8)));
      end else begin
        send_request(action_e'($urandom_range(1)),
                     ($urandom_range(3) == 0) ? 0 : $urandom_range(MAX_PAGES),
                     ($urandom_range(7) == 0) ? '0 : ADDR_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_ignored_requests();
    test_allocation_extremes();
    test_free_range();
    test_pool_resize();
    test_address_wrap();
    test_random_traffic(20, 67, 20'($urandom_range(1, 20'hFFFFF)), 11'd1024);
    test_random_traffic(67, 20, 20'd0, 11'd96);
    test_random_traffic(0, 0, 20'd1048000, 11'd1024);

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests (%0d allocate, %0d free) across %0d register writes.",
             requests, allocs, frees, reg_writes);
    $display("Checked %0d responses: %0d no-space, %0d out-of-range, %0d ignored.",
             responses, nospace_cnt, range_cnt, ignored_cnt);
    if (mismatches == 0 && pending_rsp_q.size() == 0) begin
      $display("bitmap_page_allocator_core_tb OK");
    end else begin
      $display("%0d mismatches, %0d responses missing", mismatches, pending_rsp_q.size());
      $display("bitmap_page_allocator_core_tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/bpa_pkg.sv
src/bpa_bitmap_ram.sv
src/bpa_word_scan.sv
src/bitmap_page_allocator_core.sv
tb/sv/bitmap_page_allocator_core_tb.sv
